// ===== design/scm_pkg.sv =====
// ----------------------------------------------------------------------------
// Span mask collision package
// Shared types and constants for the two-sprite span collision test.
// ----------------------------------------------------------------------------
package scm_pkg;

  // Default table depth: rows and columns per sprite.
  localparam int MAX_EXTENT_DEF = 64;

  // Field widths of one stored span.
  localparam int START_W = 6;
  localparam int STOP_W  = 7;
  localparam int INDEX_W = 6;
  localparam int OFS_W   = 8;

  // Request operation codes.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Write target selectors.
  localparam logic SEL_FIRST  = 1'b0;
  localparam logic SEL_SECOND = 1'b1;
  localparam logic AXIS_ROW   = 1'b0;
  localparam logic AXIS_COL   = 1'b1;

  // One optional half-open span [start, stop).
  typedef struct packed {
    logic               present;
    logic [START_W-1:0] start;
    logic [STOP_W-1:0]  stop;
  } span_t;

endpackage

// ===== design/scm_if.sv =====
// ----------------------------------------------------------------------------
// Span mask collision channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface scm_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic                          mask_sel;
  logic                          axis;
  logic [scm_pkg::INDEX_W-1:0]   entry_index;
  logic                          span_present;
  logic [scm_pkg::START_W-1:0]   span_start;
  logic [scm_pkg::STOP_W-1:0]    span_stop;
  logic signed [scm_pkg::OFS_W-1:0] offset_x;
  logic signed [scm_pkg::OFS_W-1:0] offset_y;

  modport source (
    output valid, op, mask_sel, axis, entry_index, span_present, span_start,
           span_stop, offset_x, offset_y,
    input  ready
  );
  modport sink (
    input  valid, op, mask_sel, axis, entry_index, span_present, span_start,
           span_stop, offset_x, offset_y,
    output ready
  );
endinterface

interface scm_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ===== design/scm_span_mem.sv =====
// ----------------------------------------------------------------------------
// Span table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scm_span_mem #(
  parameter int DEPTH = scm_pkg::MAX_EXTENT_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  scm_pkg::span_t           wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output scm_pkg::span_t           rdata_o
);

  scm_pkg::span_t mem_q [DEPTH];
  scm_pkg::span_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/scm_overlap_unit.sv =====
// ----------------------------------------------------------------------------
// Span overlap unit
// Shifts one span, tests it against another and accumulates any overlap.
// ----------------------------------------------------------------------------
module scm_overlap_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clr_i,
  input  logic                             en_i,
  input  scm_pkg::span_t                   a_i,
  input  scm_pkg::span_t                   b_i,
  input  logic signed [scm_pkg::OFS_W-1:0] shift_i,
  output logic                             hit_o
);

  localparam int CW = 10;

  logic signed [CW-1:0] s1, e1, s2, e2;
  logic                 ovl;
  logic                 acc_q, acc_d;

  // Place both spans on a common signed axis; b is moved by the shift.
  assign s1 = $signed(CW'(a_i.start));
  assign e1 = $signed(CW'(a_i.stop));
  assign s2 = $signed(CW'(b_i.start)) + CW'(shift_i);
  assign e2 = $signed(CW'(b_i.stop)) + CW'(shift_i);

  // Literal half-open overlap test; an absent span never overlaps.
  assign ovl = a_i.present && b_i.present &&
               (((s1 <= s2) && (s2 < e1)) || ((s2 <= s1) && (s1 < e2)));

  // The result includes the pair presented in this cycle.
  assign hit_o = acc_q | (en_i & ovl);
  assign acc_d = clr_i ? 1'b0 : hit_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== design/span_mask_collision_test_top.sv =====
// ----------------------------------------------------------------------------
// Span mask collision test
// Two-sprite collision test over per-row and per-column span tables.
// ----------------------------------------------------------------------------
// Write request: accepted while idle, produces no response. Query request: the
// response is set by one row pass and one column pass through the shared overlap
// unit at one table pair per cycle, each pass closed by a closing state. Ready
// returns in the cycle the response appears; a response not yet taken by then holds
// the block in its last cycle. After reset a clearing pass over all MAX_EXTENT
// entries empties all tables; requests wait until it ends.
module span_mask_collision_test_top #(
  parameter int MAX_EXTENT = scm_pkg::MAX_EXTENT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scm_req_if.sink   req_i,
  scm_rsp_if.source rsp_o
);

  localparam int IDX_W = $clog2(MAX_EXTENT);
  localparam int EW    = ((IDX_W > scm_pkg::INDEX_W) ? IDX_W : scm_pkg::INDEX_W) + 1;
  localparam int JW    = ((IDX_W > scm_pkg::OFS_W) ? IDX_W : scm_pkg::OFS_W) + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_EXTENT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_ROW_END,
    ST_COL,
    ST_COL_END
  } state_e;

  state_e                            state_q, state_d;
  logic [IDX_W-1:0]                  cnt_q, cnt_d;
  logic signed [scm_pkg::OFS_W-1:0]  ox_q, ox_d, oy_q, oy_d;
  logic                              rd_valid_q, rd_valid_d;
  logic                              row_hit_q, row_hit_d;
  logic                              hit_q, hit_d;
  logic                              out_valid_q, out_valid_d;

  logic                              req_acc;
  logic                              wr_in_range;
  logic [EW-1:0]                     idx_ext;
  logic                              issuing;
  logic                              col_issue;
  logic                              col_data;
  logic signed [scm_pkg::OFS_W-1:0]  shift_idx;
  logic signed [scm_pkg::OFS_W-1:0]  shift_pos;
  logic signed [JW-1:0]              j;
  logic                              j_in;
  logic [IDX_W-1:0]                  b_addr;
  logic [IDX_W-1:0]                  waddr;
  scm_pkg::span_t                    wdata;
  logic [3:0]                        we;
  scm_pkg::span_t                    rdata [4];
  scm_pkg::span_t                    span_a, span_b;
  logic                              unit_clr;
  logic                              unit_hit;
  logic                              slot_free;

  // Handshakes.
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.hit   = hit_q;
  assign slot_free   = !out_valid_q || rsp_o.ready;

  // Write decode: entries beyond the table are dropped.
  assign idx_ext     = EW'(req_i.entry_index);
  assign wr_in_range = idx_ext < EW'(MAX_EXTENT);
  assign waddr       = (state_q == ST_CLEAR) ? cnt_q : idx_ext[IDX_W-1:0];
  assign wdata       = (state_q == ST_CLEAR) ? '0 :
                       scm_pkg::span_t'{present: req_i.span_present,
                                        start:   req_i.span_start,
                                        stop:    req_i.span_stop};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      we[k] = (state_q == ST_CLEAR) ||
              (req_acc && (req_i.op == scm_pkg::OP_WRITE) && wr_in_range &&
               ({req_i.mask_sel, req_i.axis} == 2'(k)));
    end
  end

  // Pair index for sprite two: r minus the offset along the walked axis.
  assign issuing   = (state_q == ST_ROW) || (state_q == ST_COL);
  assign col_issue = (state_q == ST_COL);
  assign shift_idx = col_issue ? ox_q : oy_q;
  assign j         = $signed(JW'(cnt_q)) - JW'(shift_idx);
  assign j_in      = (j >= 0) && (j < $signed(JW'(MAX_EXTENT)));
  assign b_addr    = j[IDX_W-1:0];

  // Span tables: index {mask_sel, axis}.
  for (genvar k = 0; k < 4; k++) begin : g_tab
    scm_span_mem #(
      .DEPTH (MAX_EXTENT)
    ) u_mem (
      .clk_i   (clk_i),
      .we_i    (we[k]),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .raddr_i ((k >= 2) ? b_addr : cnt_q),
      .rdata_o (rdata[k])
    );
  end

  // Read data arrives in the cycle after issue; select the axis being tested.
  assign col_data  = (state_q == ST_COL) || (state_q == ST_COL_END);
  assign span_a    = col_data ? rdata[1] : rdata[0];
  assign span_b    = col_data ? rdata[3] : rdata[2];
  assign shift_pos = col_data ? oy_q : ox_q;
  assign unit_clr  = (state_q == ST_IDLE) || (state_q == ST_ROW_END);

  scm_overlap_unit u_ovl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (unit_clr),
    .en_i    (rd_valid_q),
    .a_i     (span_a),
    .b_i     (span_b),
    .shift_i (shift_pos),
    .hit_o   (unit_hit)
  );

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    rd_valid_d  = issuing && j_in;
    row_hit_d   = row_hit_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !rsp_o.ready;

    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_acc && (req_i.op == scm_pkg::OP_QUERY)) begin
          ox_d    = req_i.offset_x;
          oy_d    = req_i.offset_y;
          cnt_d   = '0;
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = ST_ROW_END;
        end
      end
      ST_ROW_END: begin
        row_hit_d = unit_hit;
        state_d   = ST_COL;
      end
      ST_COL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = ST_COL_END;
        end
      end
      ST_COL_END: begin
        // Hold until the response register is free.
        if (slot_free) begin
          hit_d       = row_hit_q && unit_hit;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      row_hit_q   <= 1'b0;
      hit_q       <= 1'b0;
      ox_q        <= '0;
      oy_q        <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
      row_hit_q   <= row_hit_d;
      hit_q       <= hit_d;
      ox_q        <= ox_d;
      oy_q        <= oy_d;
    end
  end

  // A response appears only at the end of a column pass.
  a_rsp_from_col_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_COL_END))
    else $error("response raised outside the end of a query");

  // An accepted query starts the row pass next cycle.
  a_query_starts_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_i.op == scm_pkg::OP_QUERY)) |=> (state_q == ST_ROW))
    else $error("accepted query did not start the row pass");

  // Table reads only complete during a pass or its closing cycle.
  a_read_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> ((state_q == ST_ROW) || (state_q == ST_ROW_END) ||
                    (state_q == ST_COL) || (state_q == ST_COL_END)))
    else $error("read data valid outside a query pass");

  // Item writes never collide with the clearing pass.
  a_no_write_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !req_acc)
    else $error("request accepted during the clearing pass");

endmodule
